/* src/vtb_pkg.sv */
// types, constants and helpers for the vertex transform and bounding box block
// no dependencies; used by vertex_transform_bbox
package vtb_pkg;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned TRIG_W     = 16;
	localparam int unsigned TRIG_FRAC  = 14;
	localparam int unsigned PROD_W     = 64;
	// two 32x16 products summed, one extra bit of headroom
	localparam int unsigned ACC_W      = 49;
	localparam int unsigned CFG_IDX_W  = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_COS_ANGLE   = 3'd0;
	localparam cfg_idx_t REG_SIN_ANGLE   = 3'd1;
	localparam cfg_idx_t REG_SCALE_X     = 3'd2;
	localparam cfg_idx_t REG_SCALE_Y     = 3'd3;
	localparam cfg_idx_t REG_TRANSLATE_X = 3'd4;
	localparam cfg_idx_t REG_TRANSLATE_Y = 3'd5;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_MSX  = 10'b00_0000_0010,
		ST_MSY  = 10'b00_0000_0100,
		ST_MC0  = 10'b00_0000_1000,
		ST_MC1  = 10'b00_0001_0000,
		ST_MC2  = 10'b00_0010_0000,
		ST_MC3  = 10'b00_0100_0000,
		ST_FIN  = 10'b00_1000_0000,
		ST_WY   = 10'b01_0000_0000,
		ST_BOX  = 10'b10_0000_0000
	} state_t;

	// clamp a wide signed value to the signed 32 bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(64'sh0000_0000_7fff_ffff);
		lo = PROD_W'(64'shffff_ffff_8000_0000);
		if (v > hi)
			return 32'sh7fff_ffff;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

/* src/vertex_transform_bbox.sv */
// vertex_transform_bbox: per-axis scale, rotate, translate of one vertex and running box
// steps: msx, msy, mc0 to mc3, fin, wy, then box, which loads the output register;
// six products share one 32x32 multiplier under a 10-state sequencer; a new vertex
// is taken only in idle, even while the previous result waits in the output register
// reset (arst_n low): config to identity transform, box tracker cleared, new set pending
// depends on vtb_pkg
module vertex_transform_bbox #(
	parameter int unsigned COORD_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vtb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [vtb_pkg::COORD_W-1:0]           cfg_data,
	// vertex input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [vtb_pkg::COORD_W-1:0]    local_x,
	input  logic signed [vtb_pkg::COORD_W-1:0]    local_y,
	input  logic                                  last_vertex,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [vtb_pkg::COORD_W-1:0]    world_x,
	output logic signed [vtb_pkg::COORD_W-1:0]    world_y,
	output logic                                  box_valid,
	output logic signed [vtb_pkg::COORD_W-1:0]    box_min_x,
	output logic signed [vtb_pkg::COORD_W-1:0]    box_min_y,
	output logic signed [vtb_pkg::COORD_W-1:0]    box_max_x,
	output logic signed [vtb_pkg::COORD_W-1:0]    box_max_y
);

	localparam int unsigned CW = vtb_pkg::COORD_W;
	localparam int unsigned PW = vtb_pkg::PROD_W;
	localparam int unsigned AW = vtb_pkg::ACC_W;
	localparam int unsigned TW = vtb_pkg::TRIG_W;

	// configuration registers
	logic signed [TW-1:0] cos_q;
	logic signed [TW-1:0] sin_q;
	logic signed [CW-1:0] scale_x_q;
	logic signed [CW-1:0] scale_y_q;
	logic signed [CW-1:0] trans_x_q;
	logic signed [CW-1:0] trans_y_q;

	// sequencer and working registers
	vtb_pkg::state_t      state_q;
	logic signed [CW-1:0] lx_q;
	logic signed [CW-1:0] ly_q;
	logic                 last_q;
	logic signed [CW-1:0] sx_q;
	logic signed [CW-1:0] sy_q;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;
	logic signed [CW-1:0] wx_q;
	logic signed [CW-1:0] wy_q;

	// box tracker
	logic signed [CW-1:0] run_min_x_q;
	logic signed [CW-1:0] run_min_y_q;
	logic signed [CW-1:0] run_max_x_q;
	logic signed [CW-1:0] run_max_y_q;
	logic                 first_q;

	// output register
	logic                 out_valid_q;

	// shared multiplier
	logic signed [CW-1:0] mul_a;
	logic signed [CW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;

	// combinational helpers
	logic signed [PW-1:0] scaled_wide;
	logic signed [CW-1:0] scaled_sat;
	logic signed [AW-1:0] rot_wide;
	logic signed [PW-1:0] world_wide_x;
	logic signed [PW-1:0] world_wide_y;
	logic signed [CW-1:0] nmin_x;
	logic signed [CW-1:0] nmin_y;
	logic signed [CW-1:0] nmax_x;
	logic signed [CW-1:0] nmax_y;
	logic                 box_go;
	logic                 in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == vtb_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// the box step waits until the output register is free
	assign box_go    = (state_q == vtb_pkg::ST_BOX) && (!out_valid_q || out_ready);

	// operand select for the one multiplier, by step
	always_comb begin
		mul_a = lx_q;
		mul_b = scale_x_q;
		case (state_q)
			vtb_pkg::ST_MSX: begin
				mul_a = lx_q;
				mul_b = scale_x_q;
			end
			vtb_pkg::ST_MSY: begin
				mul_a = ly_q;
				mul_b = scale_y_q;
			end
			vtb_pkg::ST_MC0: begin
				mul_a = sx_q;
				mul_b = CW'(cos_q);
			end
			vtb_pkg::ST_MC1: begin
				mul_a = sy_q;
				mul_b = CW'(sin_q);
			end
			vtb_pkg::ST_MC2: begin
				mul_a = sx_q;
				mul_b = CW'(sin_q);
			end
			vtb_pkg::ST_MC3: begin
				mul_a = sy_q;
				mul_b = CW'(cos_q);
			end
			default: begin
				mul_a = lx_q;
				mul_b = scale_x_q;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// scaled coordinate: floor shift of the last product, then clamp
	assign scaled_wide = prod_q >>> COORD_FRAC_BITS;
	assign scaled_sat  = vtb_pkg::sat32(scaled_wide);

	// y rotation sum is finished in the fin step; x sum sits in acc_q by mc3
	assign rot_wide     = acc_q + AW'(prod_q);
	assign world_wide_x = PW'(acc_q >>> vtb_pkg::TRIG_FRAC) + PW'(trans_x_q);
	assign world_wide_y = PW'(acc_q >>> vtb_pkg::TRIG_FRAC) + PW'(trans_y_q);

	// running bounds including the current vertex
	always_comb begin
		if (first_q) begin
			nmin_x = wx_q;
			nmax_x = wx_q;
			nmin_y = wy_q;
			nmax_y = wy_q;
		end else begin
			nmin_x = (wx_q < run_min_x_q) ? wx_q : run_min_x_q;
			nmax_x = (wx_q > run_max_x_q) ? wx_q : run_max_x_q;
			nmin_y = (wy_q < run_min_y_q) ? wy_q : run_min_y_q;
			nmax_y = (wy_q > run_max_y_q) ? wy_q : run_max_y_q;
		end
	end

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q     <= 16'sd16384;
			sin_q     <= '0;
			scale_x_q <= 32'sd65536;
			scale_y_q <= 32'sd65536;
			trans_x_q <= '0;
			trans_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vtb_pkg::REG_COS_ANGLE:   cos_q     <= cfg_data[TW-1:0];
				vtb_pkg::REG_SIN_ANGLE:   sin_q     <= cfg_data[TW-1:0];
				vtb_pkg::REG_SCALE_X:     scale_x_q <= cfg_data;
				vtb_pkg::REG_SCALE_Y:     scale_y_q <= cfg_data;
				vtb_pkg::REG_TRANSLATE_X: trans_x_q <= cfg_data;
				vtb_pkg::REG_TRANSLATE_Y: trans_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtb_pkg::ST_IDLE;
		end else begin
			case (state_q)
				vtb_pkg::ST_IDLE: if (in_fire) state_q <= vtb_pkg::ST_MSX;
				vtb_pkg::ST_MSX:  state_q <= vtb_pkg::ST_MSY;
				vtb_pkg::ST_MSY:  state_q <= vtb_pkg::ST_MC0;
				vtb_pkg::ST_MC0:  state_q <= vtb_pkg::ST_MC1;
				vtb_pkg::ST_MC1:  state_q <= vtb_pkg::ST_MC2;
				vtb_pkg::ST_MC2:  state_q <= vtb_pkg::ST_MC3;
				vtb_pkg::ST_MC3:  state_q <= vtb_pkg::ST_FIN;
				vtb_pkg::ST_FIN:  state_q <= vtb_pkg::ST_WY;
				vtb_pkg::ST_WY:   state_q <= vtb_pkg::ST_BOX;
				vtb_pkg::ST_BOX:  if (box_go) state_q <= vtb_pkg::ST_IDLE;
				default:          state_q <= vtb_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lx_q   <= local_x;
			ly_q   <= local_y;
			last_q <= last_vertex;
		end
		// product register, loaded on every multiply step
		if (state_q == vtb_pkg::ST_MSX || state_q == vtb_pkg::ST_MSY ||
				state_q == vtb_pkg::ST_MC0 || state_q == vtb_pkg::ST_MC1 ||
				state_q == vtb_pkg::ST_MC2 || state_q == vtb_pkg::ST_MC3) begin
			prod_q <= mul_p;
		end
		case (state_q)
			vtb_pkg::ST_MSY: sx_q <= scaled_sat;
			vtb_pkg::ST_MC0: sy_q <= scaled_sat;
			// sx*cos
			vtb_pkg::ST_MC1: acc_q <= AW'(prod_q);
			// minus sy*sin
			vtb_pkg::ST_MC2: acc_q <= acc_q - AW'(prod_q);
			vtb_pkg::ST_MC3: begin
				wx_q  <= vtb_pkg::sat32(world_wide_x);
				acc_q <= AW'(prod_q);
			end
			// sx*sin plus sy*cos
			vtb_pkg::ST_FIN: acc_q <= rot_wide;
			vtb_pkg::ST_WY:  wy_q  <= vtb_pkg::sat32(world_wide_y);
			default: ;
		endcase
	end

	// box tracker, first-of-set flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_x_q <= '0;
			run_min_y_q <= '0;
			run_max_x_q <= '0;
			run_max_y_q <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (box_go) begin
				run_min_x_q <= nmin_x;
				run_min_y_q <= nmin_y;
				run_max_x_q <= nmax_x;
				run_max_y_q <= nmax_y;
				first_q     <= last_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register, box fields zero unless the set closes
	always_ff @(posedge clk) begin
		if (box_go) begin
			world_x   <= wx_q;
			world_y   <= wy_q;
			box_valid <= last_q;
			box_min_x <= last_q ? nmin_x : '0;
			box_min_y <= last_q ? nmin_y : '0;
			box_max_x <= last_q ? nmax_x : '0;
			box_max_y <= last_q ? nmax_y : '0;
		end
	end

endmodule

/* bench/vertex_transform_bbox_test.sv */
// self-checking bench for vertex_transform_bbox: per-axis scale, rotation, translation
// and running bounding box, every output beat compared with an in-bench fixed-point model
// depends on vtb_pkg and vertex_transform_bbox
module vertex_transform_bbox_test;

	localparam int unsigned FRAC_BITS       = 16;
	localparam int unsigned CYCLE_LIMIT     = 500000;
	localparam int unsigned SETTLE_CYCLES   = 20;
	localparam int unsigned RANDOM_PHASES   = 10;
	localparam int unsigned PHASE_VERTICES  = 200;
	localparam int unsigned STALL_HOLD      = 300;

	// indexes with no register behind them, writes there must change nothing
	localparam vtb_pkg::cfg_idx_t REG_SPARE_6 = 3'd6;
	localparam vtb_pkg::cfg_idx_t REG_SPARE_7 = 3'd7;

	typedef logic signed [vtb_pkg::COORD_W-1:0] coord_t;
	typedef logic signed [vtb_pkg::TRIG_W-1:0]  trig_t;

	localparam coord_t COORD_MAX = 32'sh7fff_ffff;
	localparam coord_t COORD_MIN = 32'sh8000_0000;
	localparam coord_t ONE_Q16   = 32'sh0001_0000;
	localparam trig_t  ONE_Q14   = 16'sh4000;
	localparam trig_t  TRIG_MAX  = 16'sh7fff;
	localparam trig_t  TRIG_MIN  = 16'sh8000;

	// one result beat as the block should present it
	typedef struct packed {
		coord_t world_x;
		coord_t world_y;
		logic   box_valid;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_max_x;
		coord_t box_max_y;
	} vertex_result_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_valid;
	logic     cfg_ready;
	vtb_pkg::cfg_idx_t cfg_index;
	logic [vtb_pkg::COORD_W-1:0] cfg_data;
	logic     in_valid;
	logic     in_ready;
	coord_t   local_x;
	coord_t   local_y;
	logic     last_vertex;
	logic     out_valid;
	logic     out_ready;
	coord_t   world_x;
	coord_t   world_y;
	logic     box_valid;
	coord_t   box_min_x;
	coord_t   box_min_y;
	coord_t   box_max_x;
	coord_t   box_max_y;

	vertex_transform_bbox #(
		.COORD_FRAC_BITS(FRAC_BITS)
	) uut (.*);

	// bench copy of the configuration, tracks every accepted register write
	trig_t  cur_cos;
	trig_t  cur_sin;
	coord_t cur_scale_x;
	coord_t cur_scale_y;
	coord_t cur_shift_x;
	coord_t cur_shift_y;

	// bench copy of the box tracker
	coord_t box_lo_x;
	coord_t box_lo_y;
	coord_t box_hi_x;
	coord_t box_hi_y;
	logic   starting_set;

	// results predicted at input beats, oldest first
	vertex_result_t expected_results[$];

	int errors          = 0;
	int vertices_sent   = 0;
	int sets_closed     = 0;
	int results_checked = 0;
	int cfg_writes      = 0;
	int cycle_count     = 0;

	// idling switches and the one-shot long hold of the result side
	bit sender_idles    = 1'b1;
	bit receiver_idles  = 1'b1;
	int hold_off_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped at cycle limit %0d with %0d results outstanding",
			cycle_count, expected_results.size());
		$display("Some tests failed");
		$finish;
	end

	// clamp to the signed 32 bit range: in range when the top 33 bits all match the sign
	function automatic coord_t clamp_coord(input logic signed [63:0] v);
		if (v[63:31] == {33{v[63]}})
			return v[31:0];
		return v[63] ? COORD_MIN : COORD_MAX;
	endfunction

	// world vertex of one local vertex plus the box bookkeeping, result goes to the queue
	task automatic transform_vertex(input coord_t lx, input coord_t ly, input logic last);
		logic signed [63:0] prod_x;
		logic signed [63:0] prod_y;
		logic signed [63:0] rot_x;
		logic signed [63:0] rot_y;
		coord_t scl_x;
		coord_t scl_y;
		coord_t wx;
		coord_t wy;
		vertex_result_t r;
		// per-axis scale, floor back to the coordinate format, clamp
		prod_x = lx * cur_scale_x;
		prod_y = ly * cur_scale_y;
		scl_x  = clamp_coord(prod_x >>> FRAC_BITS);
		scl_y  = clamp_coord(prod_y >>> FRAC_BITS);
		// rotation kept wide, floor by the trig fraction, no clamp until translated
		rot_x  = (scl_x * cur_cos - scl_y * cur_sin) >>> vtb_pkg::TRIG_FRAC;
		rot_y  = (scl_x * cur_sin + scl_y * cur_cos) >>> vtb_pkg::TRIG_FRAC;
		wx     = clamp_coord(rot_x + cur_shift_x);
		wy     = clamp_coord(rot_y + cur_shift_y);
		// first vertex of a set seeds the box, later ones widen it
		if (starting_set) begin
			box_lo_x = wx;
			box_hi_x = wx;
			box_lo_y = wy;
			box_hi_y = wy;
		end else begin
			if (wx < box_lo_x) box_lo_x = wx;
			if (wx > box_hi_x) box_hi_x = wx;
			if (wy < box_lo_y) box_lo_y = wy;
			if (wy > box_hi_y) box_hi_y = wy;
		end
		r.world_x   = wx;
		r.world_y   = wy;
		r.box_valid = last;
		// box fields read zero except on the closing vertex
		r.box_min_x = last ? box_lo_x : '0;
		r.box_min_y = last ? box_lo_y : '0;
		r.box_max_x = last ? box_hi_x : '0;
		r.box_max_y = last ? box_hi_y : '0;
		starting_set = last;
		expected_results.insert(expected_results.size(), r);
	endtask

	// all driving tasks are entered and left just after a falling edge
	task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
		int gap;
		gap = sender_idles ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		local_x     <= x;
		local_y     <= y;
		last_vertex <= last;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		transform_vertex(x, y, last);
		vertices_sent++;
		if (last)
			sets_closed++;
		@(negedge clk);
	endtask

	// sender goes quiet until every predicted beat has been seen
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input vtb_pkg::cfg_idx_t idx,
		input logic [vtb_pkg::COORD_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			vtb_pkg::REG_COS_ANGLE:   cur_cos     = data[vtb_pkg::TRIG_W-1:0];
			vtb_pkg::REG_SIN_ANGLE:   cur_sin     = data[vtb_pkg::TRIG_W-1:0];
			vtb_pkg::REG_SCALE_X:     cur_scale_x = data;
			vtb_pkg::REG_SCALE_Y:     cur_scale_y = data;
			vtb_pkg::REG_TRANSLATE_X: cur_shift_x = data;
			vtb_pkg::REG_TRANSLATE_Y: cur_shift_y = data;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	// full reprogram on an idle block; trig writes carry junk in the unused upper half,
	// and a spare index is written last so a decode alias would corrupt a live register
	task automatic apply_settings(input trig_t c, input trig_t s, input coord_t sx,
		input coord_t sy, input coord_t tx, input coord_t ty);
		drain_results();
		write_reg(vtb_pkg::REG_COS_ANGLE, {16'($urandom), c});
		write_reg(vtb_pkg::REG_SIN_ANGLE, {16'($urandom), s});
		write_reg(vtb_pkg::REG_SCALE_X, sx);
		write_reg(vtb_pkg::REG_SCALE_Y, sy);
		write_reg(vtb_pkg::REG_TRANSLATE_X, tx);
		write_reg(vtb_pkg::REG_TRANSLATE_Y, ty);
		write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// mostly within +-2^(span_bits-1) raw units, now and then any value or an extreme
	function automatic coord_t pick_value(input int unsigned span_bits);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: case ($urandom_range(0, 3))
				0: return COORD_MAX;
				1: return COORD_MIN;
				2: return '0;
				default: return -1;
			endcase
			default: return coord_t'(int'($urandom_range(0, (1 << span_bits) - 1))
				- (1 << (span_bits - 1)));
		endcase
	endfunction

	// mostly within +-1.0, sometimes any 16 bit pattern
	function automatic trig_t pick_trig();
		if ($urandom_range(0, 4) == 0)
			return trig_t'($urandom);
		return trig_t'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	task automatic compare_field(input string field, input logic [vtb_pkg::COORD_W-1:0] want,
		input logic [vtb_pkg::COORD_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d (%h) actual %0d (%h)", $time,
				field, $signed(want), want, $signed(got), got);
		end
	endtask

	// result side: random or long stalls, then every accepted beat checked in order
	initial begin : result_sink
		int stall;
		vertex_result_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				stall = receiver_idles ? $urandom_range(0, 15) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, world %0d,%0d",
					$time, world_x, world_y);
			end else begin
				want = expected_results.pop_front();
				compare_field("world_x", want.world_x, world_x);
				compare_field("world_y", want.world_y, world_y);
				compare_field("box_valid", want.box_valid, box_valid);
				compare_field("box_min_x", want.box_min_x, box_min_x);
				compare_field("box_min_y", want.box_min_y, box_min_y);
				compare_field("box_max_x", want.box_max_x, box_max_x);
				compare_field("box_max_y", want.box_max_y, box_max_y);
				results_checked++;
			end
			@(negedge clk);
		end
	end

	// reset configuration is the identity, so world equals local
	task automatic test_identity_after_reset();
		// a lone closing vertex gives a box of one point
		send_vertex('0, '0, 1'b1);
		send_vertex(COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MIN, COORD_MAX, 1'b0);
		send_vertex(-1, 1, 1'b0);
		send_vertex(32'sh0001_8000, -32'sh0002_4000, 1'b1);
		drain_results();
	endtask

	// every register, trig values past unity, both kinds of saturation
	task automatic test_register_settings();
		// quarter turn
		apply_settings('0, ONE_Q14, ONE_Q16, ONE_Q16, '0, '0);
		send_vertex(ONE_Q16, '0, 1'b0);
		send_vertex('0, ONE_Q16, 1'b1);
		// trig extremes used as given, uneven and negative scale, offset
		apply_settings(TRIG_MIN, TRIG_MAX, 32'sh0002_8000, -32'sh0000_c000,
			32'sh0003_0000, -32'sh0007_0000);
		send_vertex(32'sh0004_2000, -32'sh0001_0000, 1'b0);
		send_vertex(-32'sh0010_0000, 32'sh0020_0001, 1'b0);
		send_vertex(32'sh0000_0001, 32'sh0000_0003, 1'b1);
		// scaled coordinates clamp on both sides
		apply_settings(ONE_Q14, '0, COORD_MAX, COORD_MIN, '0, '0);
		send_vertex(COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MIN, COORD_MAX, 1'b0);
		send_vertex(ONE_Q16, -ONE_Q16, 1'b1);
		// world coordinates clamp after translation
		apply_settings(ONE_Q14, -ONE_Q14, ONE_Q16, ONE_Q16, COORD_MAX, COORD_MIN);
		send_vertex(COORD_MAX, COORD_MAX, 1'b0);
		send_vertex(COORD_MIN, COORD_MIN, 1'b0);
		send_vertex('0, '0, 1'b1);
		// everything zero except the offset
		apply_settings('0, '0, '0, '0, -32'sh1234_5678, 32'sh0765_4321);
		send_vertex($urandom, $urandom, 1'b1);
		// both trig at minus one
		apply_settings(-ONE_Q14, -ONE_Q14, ONE_Q16, ONE_Q16, 32'sh0100_0000, '0);
		send_vertex(32'sh0003_0000, 32'sh0001_0000, 1'b0);
		send_vertex(-32'sh0002_0000, 32'sh0005_0000, 1'b0);
		send_vertex(32'sh0000_8000, -32'sh0006_0000, 1'b1);
		drain_results();
	endtask

	// result side holds off long while the sender streams, input must back up
	task automatic test_output_stall();
		int i;
		drain_results();
		sender_idles    = 1'b0;
		hold_off_cycles = STALL_HOLD;
		for (i = 0; i < 24; i++)
			send_vertex(pick_value(24), pick_value(24), (i % 4) == 3);
		drain_results();
		sender_idles = 1'b1;
	endtask

	// random or extreme settings, random sets of random length, idling mix per phase
	task automatic test_random_sets();
		int phase;
		int sent;
		int len;
		int i;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1: apply_settings(TRIG_MAX, TRIG_MAX, COORD_MAX, COORD_MAX,
					COORD_MAX, COORD_MAX);
				2: apply_settings(TRIG_MIN, TRIG_MIN, COORD_MIN, COORD_MIN,
					COORD_MIN, COORD_MIN);
				default: apply_settings(pick_trig(), pick_trig(), pick_value(19),
					pick_value(19), pick_value(28), pick_value(28));
			endcase
			// both idle, one side busy flat out, both flat out
			sender_idles   = (phase % 4) != 1 && (phase % 4) != 3;
			receiver_idles = (phase % 4) != 2 && (phase % 4) != 3;
			sent = 0;
			while (sent < PHASE_VERTICES) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
				for (i = 0; i < len; i++)
					send_vertex(pick_value(24), pick_value(24), i == len - 1);
				sent += len;
			end
		end
		drain_results();
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	initial begin : stimulus
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = vtb_pkg::REG_COS_ANGLE;
		cfg_data    = '0;
		in_valid    = 1'b0;
		local_x     = '0;
		local_y     = '0;
		last_vertex = 1'b0;
		// bench model starts from the reset state of the block
		cur_cos      = ONE_Q14;
		cur_sin      = '0;
		cur_scale_x  = ONE_Q16;
		cur_scale_y  = ONE_Q16;
		cur_shift_x  = '0;
		cur_shift_y  = '0;
		box_lo_x     = '0;
		box_lo_y     = '0;
		box_hi_x     = '0;
		box_hi_y     = '0;
		starting_set = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_identity_after_reset();
		test_register_settings();
		test_output_stall();
		test_random_sets();

		// settle: anything extra coming out now is flagged by the result side
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d predicted results never came out", $time,
				expected_results.size());
		end

		$display("covered %0d vertices in %0d closed sets, %0d result beats compared",
			vertices_sent, sets_closed, results_checked);
		$display("with %0d register writes over %0d cycles, %0d mismatches seen",
			cfg_writes, cycle_count, errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
src/vtb_pkg.sv
src/vertex_transform_bbox.sv
bench/vertex_transform_bbox_test.sv
